// ===== src/pce_pkg.sv =====
// ----------------------------------------------------------------------------
// pce_pkg
// Shared constants, codes and types of the piecewise cubic evaluator.
// ----------------------------------------------------------------------------
package pce_pkg;

  // Spline size
  localparam int unsigned MAX_NODES = 8;
  localparam int unsigned NUM_SEGS  = MAX_NODES - 1;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned SEG_W     = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_NODES + 1);

  // Field widths
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SEGOUT_W  = 3;
  localparam int unsigned NODES_W   = 4;
  localparam int unsigned ACC_W     = 128;

  // Coefficient terms within a segment
  localparam int unsigned TERM_A    = 0;
  localparam int unsigned TERM_B    = 1;
  localparam int unsigned TERM_C    = 2;
  localparam int unsigned TERM_D    = 3;
  localparam int unsigned NUM_TERMS = 4;

  // Register file
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_NODES_IN_USE = '0;
  localparam logic [NODES_W-1:0]   NODES_RESET      = 4'd8;

  // Round to nearest at the Q16.16 point of a 2^-64 sum
  localparam logic [ACC_W-1:0] ROUND_HALF = {{(ACC_W-48){1'b0}}, 1'b1, 47'd0};

  typedef enum logic [MODE_W-1:0] {
    MODE_NODE = 2'd0,
    MODE_COEF = 2'd1,
    MODE_EVAL = 2'd2
  } pce_mode_e;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic             ext;
  } pce_meta_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
    pce_meta_t                meta;
  } pce_eval_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] spline_value;
    logic [SEGOUT_W-1:0]      segment;
    logic                     extrapolated;
  } pce_res_t;

endpackage

// ===== src/pce_if.sv =====
// ----------------------------------------------------------------------------
// pce_in_if / pce_out_if
// Valid/ready channels of the piecewise cubic evaluator.
// ----------------------------------------------------------------------------
interface pce_in_if;
  import pce_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [SLOT_W-1:0]        slot;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, mode, slot, value, input ready);
  modport sink   (input valid, mode, slot, value, output ready);
endinterface

interface pce_out_if;
  import pce_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] spline_value;
  logic [SEGOUT_W-1:0]      segment;
  logic                     extrapolated;

  modport source (output valid, spline_value, segment, extrapolated, input ready);
  modport sink   (input valid, spline_value, segment, extrapolated, output ready);
endinterface

// ===== src/piecewise_cubic_evaluator.sv =====
// ----------------------------------------------------------------------------
// piecewise_cubic_evaluator
// Piecewise cubic spline evaluation with loadable nodes and coefficients.
// ----------------------------------------------------------------------------
// Input channel in_i carries beats of {mode, slot, value}. Mode node writes
// a Q16.16 node position, mode coef writes coefficient 4*segment+term
// (a, b, c, d), mode eval evaluates the spline at x = value. Only eval beats
// produce a result beat on out_o: {spline_value, segment, extrapolated}.
// Writes take effect in beat order, so an eval sees every earlier write.
// Register nodes_in_use (APB, address 0) sets the active node count; write it
// only while the block is idle.
// Throughput: one beat per cycle while out_o does not stall, eval and write
// beats alike. An eval beat passes through the input stage, node compare plus
// coefficient RAM read, and seven arithmetic stages.
// Reset sets nodes_in_use to 8 and empties the pipeline; node and coefficient
// stores are not cleared and must be written before use.
// When out_o stalls, results back up stage by stage; in_i.ready drops only
// once every stage holds a beat. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module piecewise_cubic_evaluator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pce_in_if.sink                      in_i,
  pce_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pce_pkg::PADDR_W-1:0] paddr,
  input  logic [pce_pkg::DATA_W-1:0]  pwdata,
  output logic [pce_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import pce_pkg::*;

  // Configuration register
  logic [NODES_W-1:0]   nodes_q;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == REG_NODES_IN_USE) ? {{(DATA_W-NODES_W){1'b0}}, nodes_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q <= NODES_RESET;
    end else if (cfg_we && (reg_idx == REG_NODES_IN_USE)) begin
      nodes_q <= pwdata[NODES_W-1:0];
    end
  end

  // Stage control
  logic               s1_v_q, s2_v_q;
  logic [MODE_W-1:0]  s1_mode_q;
  logic [SLOT_W-1:0]  s1_slot_q;
  logic signed [DATA_W-1:0] s1_x_q, s2_x_q;
  pce_meta_t          s2_meta_q, seg_d;
  logic               en1, en2, ar_ready;
  logic               s1_leave, s1_eval, node_we, coef_we;

  assign en2      = !s2_v_q || ar_ready;
  assign en1      = !s1_v_q || en2;
  assign in_i.ready = en1;
  assign s1_leave = s1_v_q && en2;
  assign s1_eval  = s1_v_q && (s1_mode_q == MODE_EVAL);
  assign node_we  = s1_leave && (s1_mode_q == MODE_NODE) && (int'(s1_slot_q) < MAX_NODES);
  assign coef_we  = s1_leave && (s1_mode_q == MODE_COEF)
                    && (int'(s1_slot_q) < NUM_TERMS * NUM_SEGS);

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_q <= in_i.valid;
      end
      if (en2) begin
        s2_v_q <= s1_eval;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_mode_q <= in_i.mode;
      s1_slot_q <= in_i.slot;
      s1_x_q    <= in_i.value;
    end
    if (en2) begin
      s2_x_q    <= s1_x_q;
      s2_meta_q <= seg_d;
    end
  end

  // Node store, written as a beat leaves the input stage
  logic signed [DATA_W-1:0] node_q [MAX_NODES];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_NODES; k++) begin
      if (node_we && (int'(s1_slot_q) == k)) begin
        node_q[k] <= s1_x_q;
      end
    end
  end

  // Segment search: compare x against every node in parallel
  logic [CNT_W-1:0]     cnt_eff;
  logic [NODE_W-1:0]    last_idx;
  logic [SEG_W-1:0]     seg_last;
  logic [MAX_NODES-1:0] ge, le;

  always_comb begin
    if (int'(nodes_q) < 2) begin
      cnt_eff = CNT_W'(2);
    end else if (int'(nodes_q) > MAX_NODES) begin
      cnt_eff = CNT_W'(MAX_NODES);
    end else begin
      cnt_eff = CNT_W'(nodes_q);
    end
    last_idx = NODE_W'(cnt_eff - CNT_W'(1));
    seg_last = SEG_W'(cnt_eff - CNT_W'(2));
  end

  always_comb begin
    for (int k = 0; k < MAX_NODES; k++) begin
      ge[k] = s1_x_q >= node_q[k];
      le[k] = s1_x_q <= node_q[k];
    end
  end

  always_comb begin
    seg_d.seg = seg_last;
    seg_d.ext = 1'b0;
    if (le[0]) begin
      seg_d.seg = '0;
      seg_d.ext = !ge[0];
    end else if (ge[last_idx]) begin
      seg_d.ext = !le[last_idx];
    end else begin
      // first enclosing pair wins
      for (int k = NUM_SEGS - 1; k >= 0; k--) begin
        if (((k + 1) < int'(cnt_eff)) && ge[k] && le[k+1]) begin
          seg_d.seg = SEG_W'(k);
        end
      end
    end
  end

  // Coefficient store: one RAM per term, addressed by segment
  logic [DATA_W-1:0] coef_rd [NUM_TERMS];

  for (genvar t = 0; t < NUM_TERMS; t++) begin : g_coef
    pce_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_SEGS)
    ) u_coef_ram (
      .clk_i   (clk_i),
      .we_i    (coef_we && (s1_slot_q[1:0] == 2'(t))),
      .waddr_i (SEG_W'(s1_slot_q[SLOT_W-1:2])),
      .wdata_i (s1_x_q),
      .re_i    (en2 && s1_eval),
      .raddr_i (seg_d.seg),
      .rdata_o (coef_rd[t])
    );
  end

  // Arithmetic pipeline
  pce_eval_t eval;
  pce_res_t  res;
  logic      ar_valid;

  assign eval.x    = s2_x_q;
  assign eval.a    = $signed(coef_rd[TERM_A]);
  assign eval.b    = $signed(coef_rd[TERM_B]);
  assign eval.c    = $signed(coef_rd[TERM_C]);
  assign eval.d    = $signed(coef_rd[TERM_D]);
  assign eval.meta = s2_meta_q;

  pce_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_v_q),
    .ready_o (ar_ready),
    .eval_i  (eval),
    .valid_o (ar_valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.valid        = ar_valid;
  assign out_o.spline_value = res.spline_value;
  assign out_o.segment      = res.segment;
  assign out_o.extrapolated = res.extrapolated;

  // Checks
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en2 && !s1_eval) |=> !s2_v_q)
    else $error("write beat produced an evaluation");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (int'(s2_meta_q.seg) < NUM_SEGS))
    else $error("segment index beyond last segment");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !ar_ready) |=> (s2_v_q && $stable(s2_meta_q) && $stable(s2_x_q)))
    else $error("stalled evaluation changed");

endmodule

// ===== src/pce_ram.sv =====
// ----------------------------------------------------------------------------
// pce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pce_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 8,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pce_arith.sv =====
// ----------------------------------------------------------------------------
// pce_arith
// Seven-stage cubic datapath: a*x^3 + b*x^2 + c*x + d at 2^-64 scale,
// rounded to Q16.16 and saturated to 32 bits.
// ----------------------------------------------------------------------------
module pce_arith (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  pce_pkg::pce_eval_t eval_i,
  output logic               valid_o,
  input  logic               ready_i,
  output pce_pkg::pce_res_t  res_o
);
  import pce_pkg::*;

  localparam int unsigned NS = 7;

  // signed 32x32, full 64-bit product
  function automatic logic signed [63:0] smul(input logic signed [31:0] p,
                                              input logic signed [31:0] q);
    smul = $signed({{32{p[31]}}, p}) * $signed({{32{q[31]}}, q});
  endfunction

  // unsigned 32 limb times signed 32, 65-bit product
  function automatic logic signed [64:0] umul(input logic [31:0] p,
                                              input logic signed [31:0] q);
    umul = $signed({33'd0, p}) * $signed({{33{q[31]}}, q});
  endfunction

  logic      en   [NS];
  logic      v_q  [NS];
  pce_meta_t meta_q [NS];

  // Stage data
  logic signed [31:0]  x0_q, d0_q;
  logic signed [63:0]  ax0_q, bx0_q, cx0_q;
  logic signed [31:0]  x1_q, d1_q;
  logic signed [63:0]  ahx1_q, bhx1_q, cx1_q;
  logic signed [64:0]  alx1_q, blx1_q;
  logic signed [31:0]  x2_q, d2_q;
  logic signed [95:0]  ax2_q, bx2_q;
  logic signed [63:0]  cx2_q;
  logic signed [64:0]  m0_q, m1_q;
  logic signed [63:0]  m2_q;
  logic [ACC_W-1:0]    sbc3_q;
  logic signed [31:0]  d3_q;
  logic [ACC_W-1:0]    ax3_q, slow4_q;
  logic [ACC_W-1:0]    tot5_q;
  logic signed [31:0]  res_q;

  logic [ACC_W-1:0]    sbc_d, ax3_d, slow_d, tot_d;
  logic signed [95:0]  ax2_d, bx2_d;
  logic signed [31:0]  sat_d;

  // Stall chain: a stage advances when empty or when its successor advances
  always_comb begin
    en[NS-1] = !v_q[NS-1] || ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign ready_o = en[0];

  // Valid bits and segment info travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        v_q[k] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      meta_q[0] <= eval_i.meta;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  // Combine halves of a*x*x and b*x*x
  assign ax2_d = $signed({ahx1_q, 32'd0}) + $signed({{31{alx1_q[64]}}, alx1_q});
  assign bx2_d = $signed({bhx1_q, 32'd0}) + $signed({{31{blx1_q[64]}}, blx1_q});

  // b*x^2 * 2^16 + c*x * 2^32
  assign sbc_d = {{16{bx2_q[95]}}, bx2_q, 16'd0} + {{32{cx2_q[63]}}, cx2_q, 32'd0};

  // a*x^3 from three limb products; low terms plus d * 2^48 and rounding
  assign ax3_d  = {m2_q, 64'd0} + {{31{m1_q[64]}}, m1_q, 32'd0} + {{63{m0_q[64]}}, m0_q};
  assign slow_d = sbc3_q + {{48{d3_q[31]}}, d3_q, 48'd0} + ROUND_HALF;

  assign tot_d = ax3_q + slow4_q;

  // Saturate: the shifted value fits when bits 127..79 agree
  always_comb begin
    if ((&tot5_q[ACC_W-1:79]) || !(|tot5_q[ACC_W-1:79])) begin
      sat_d = $signed(tot5_q[79:48]);
    end else if (tot5_q[ACC_W-1]) begin
      sat_d = 32'sh8000_0000;
    end else begin
      sat_d = 32'sh7FFF_FFFF;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x0_q  <= eval_i.x;
      d0_q  <= eval_i.d;
      ax0_q <= smul(eval_i.a, eval_i.x);
      bx0_q <= smul(eval_i.b, eval_i.x);
      cx0_q <= smul(eval_i.c, eval_i.x);
    end
    if (en[1]) begin
      x1_q   <= x0_q;
      d1_q   <= d0_q;
      cx1_q  <= cx0_q;
      ahx1_q <= smul(ax0_q[63:32], x0_q);
      alx1_q <= umul(ax0_q[31:0], x0_q);
      bhx1_q <= smul(bx0_q[63:32], x0_q);
      blx1_q <= umul(bx0_q[31:0], x0_q);
    end
    if (en[2]) begin
      x2_q  <= x1_q;
      d2_q  <= d1_q;
      cx2_q <= cx1_q;
      ax2_q <= ax2_d;
      bx2_q <= bx2_d;
    end
    if (en[3]) begin
      m0_q   <= umul(ax2_q[31:0], x2_q);
      m1_q   <= umul(ax2_q[63:32], x2_q);
      m2_q   <= smul(ax2_q[95:64], x2_q);
      sbc3_q <= sbc_d;
      d3_q   <= d2_q;
    end
    if (en[4]) begin
      ax3_q   <= ax3_d;
      slow4_q <= slow_d;
    end
    if (en[5]) begin
      tot5_q <= tot_d;
    end
    if (en[6]) begin
      res_q <= sat_d;
    end
  end

  // Output beat
  assign valid_o            = v_q[NS-1];
  assign res_o.spline_value = res_q;
  assign res_o.segment      = SEGOUT_W'(meta_q[NS-1].seg);
  assign res_o.extrapolated = meta_q[NS-1].ext;

endmodule
